@@ rtl/core/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg - shared types and constants for the set-associative tag lookup
// Controller states, command/status bundles between controller and datapath,
// register map, reset values and the replacement LFSR step.
// ----------------------------------------------------------------------------
package sacl_pkg;

	// Fixed field widths
	localparam int ADDR_W  = 32;
	localparam int DELAY_W = 8;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int LFSR_W  = 8;

	// Register map, indexed by paddr[3:2]
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_HIT   = 2'd2;
	localparam logic [1:0] REG_MISS  = 2'd3;

	// Register reset values
	localparam logic [ADDR_W-1:0]  BASE_RST  = 32'h0000_0000;
	localparam logic [ADDR_W-1:0]  LIMIT_RST = 32'hFFFF_FFFF;
	localparam logic [DELAY_W-1:0] HIT_RST   = 8'd1;
	localparam logic [DELAY_W-1:0] MISS_RST  = 8'd10;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LINE,
		ST_SET,
		ST_RESULT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_en;
		logic start_line;
		logic start_set;
		logic rd_en;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic req_cacheable;
		logic line_done;
		logic set_done;
		logic out_free;
	} dp_status_t;

	// One step of the XNOR LFSR, taps 7, 3, 2, 1
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic fb;
		fb = ~(s[7] ^ s[3] ^ s[2] ^ s[1]);
		return {s[LFSR_W-2:0], fb};
	endfunction

endpackage

@@ rtl/core/sacl_div.sv @@
// ----------------------------------------------------------------------------
// sacl_div - divide by a fixed constant
// Power-of-two divisors split the dividend; any other divisor multiplies by
// a rounded-up reciprocal and keeps the top bits. Either way the quotient is
// registered at start, holds until the next start, and done pulses for one
// cycle when it is ready.
// ----------------------------------------------------------------------------
module sacl_div #(
	parameter int unsigned IN_W    = 32,
	parameter int unsigned DIVISOR = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IN_W-1:0] dividend,
	output logic [IN_W-1:0] quotient,
	output logic            done
);

	localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

	logic [IN_W-1:0] quo_q;
	logic            done_q;

	generate
		if (IS_POW2) begin : g_shift
			localparam int unsigned SHIFT = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;

			// drop the bits below the divisor's bit position
			always_ff @(posedge clk) begin
				if (start) begin
					quo_q <= dividend >> SHIFT;
				end
			end
		end else begin : g_recip
			localparam int unsigned PRE    = $clog2(DIVISOR);
			localparam int unsigned SHIFT  = IN_W + PRE;
			localparam int unsigned PROD_W = 2 * IN_W + 1;
			localparam longint unsigned RECIP =
				((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

			logic [PROD_W-1:0] prod;

			// the rounded-up reciprocal is exact for every IN_W-bit dividend
			assign prod = PROD_W'(dividend) * PROD_W'(RECIP);

			always_ff @(posedge clk) begin
				if (start) begin
					quo_q <= IN_W'(prod >> SHIFT);
				end
			end
		end
	endgenerate

	// flag the quotient in the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ rtl/core/sacl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sacl_ctrl - lookup sequencer
// Runs the valid-bit clearing pass after reset, then takes one address at a
// time to result/update, via line split, set split and row read if cacheable.
// ----------------------------------------------------------------------------
module sacl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  sacl_pkg::dp_status_t st,
	output sacl_pkg::dp_cmd_t    cmd
);

	import sacl_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (st.req_cacheable) begin
						cmd.start_line = 1'b1;
						state_d        = ST_LINE;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_LINE: begin
				if (st.line_done) begin
					cmd.start_set = 1'b1;
					state_d       = ST_SET;
				end
			end
			ST_SET: begin
				if (st.set_done) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/sacl_dp.sv @@
// ----------------------------------------------------------------------------
// sacl_dp - lookup datapath
// Range check, address split, tag and valid row memories, way compare,
// victim choice with the replacement LFSR, and the result register.
// ----------------------------------------------------------------------------
module sacl_dp #(
	parameter int unsigned WAYS       = 4,
	parameter int unsigned SETS       = 64,
	parameter int unsigned LINE_BYTES = 16,
	parameter int unsigned LINE_W     = 28,
	parameter int unsigned TAG_W      = 22,
	parameter int unsigned SET_W      = 6,
	parameter int unsigned WAY_W      = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sacl_pkg::dp_cmd_t              cmd,
	output sacl_pkg::dp_status_t           st,
	input  logic [sacl_pkg::ADDR_W-1:0]    address,
	input  logic [sacl_pkg::ADDR_W-1:0]    base,
	input  logic [sacl_pkg::ADDR_W-1:0]    limit,
	input  logic [sacl_pkg::DELAY_W-1:0]   hit_delay,
	input  logic [sacl_pkg::DELAY_W-1:0]   miss_delay,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [sacl_pkg::DELAY_W-1:0]   delay,
	output logic                           hit,
	output logic                           cacheable
);

	import sacl_pkg::*;

	// row memories, one row per set
	logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SETS];
	logic [WAYS-1:0]            valid_mem [SETS];

	logic [WAYS-1:0][TAG_W-1:0] tag_row_q;
	logic [WAYS-1:0]            valid_row_q;
	logic [WAYS-1:0][TAG_W-1:0] tag_row_new;
	logic [WAYS-1:0]            valid_row_new;

	logic [SET_W-1:0]   clr_cnt_q;
	logic               item_cacheable_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic [LFSR_W-1:0]  lfsr_nxt;

	logic [ADDR_W-1:0]  line_quo;
	logic [LINE_W-1:0]  set_quo;
	logic [LINE_W-1:0]  set_base;
	logic [SET_W-1:0]   set_idx;
	logic [TAG_W-1:0]   tag_now;
	logic               line_done;
	logic               set_done;

	logic [WAYS-1:0]    match;
	logic               hit_any;
	logic               free_found;
	logic [WAY_W-1:0]   free_way;
	logic [WAY_W:0]     rnd_ext;
	logic [WAY_W-1:0]   rnd_way;
	logic [WAY_W-1:0]   victim;
	logic               wr_en;
	logic               lfsr_adv;

	logic               out_valid_q;
	logic [DELAY_W-1:0] delay_q;
	logic               hit_q;
	logic               cach_q;

	// address -> line number
	sacl_div #(
		.IN_W    (ADDR_W),
		.DIVISOR (LINE_BYTES)
	) u_line_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_line),
		.dividend  (address),
		.quotient  (line_quo),
		.done      (line_done)
	);

	// line number -> tag
	sacl_div #(
		.IN_W    (LINE_W),
		.DIVISOR (SETS)
	) u_set_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_set),
		.dividend  (line_quo[LINE_W-1:0]),
		.quotient  (set_quo),
		.done      (set_done)
	);

	assign tag_now = set_quo[TAG_W-1:0];

	// set index is what the tag split leaves over
	assign set_base = set_quo * LINE_W'(SETS);
	assign set_idx  = SET_W'(line_quo[LINE_W-1:0] - set_base);

	// latch the range check with the item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_cacheable_q <= (address >= base) && (address <= limit);
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// read one set row
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			tag_row_q   <= tag_mem[set_idx];
			valid_row_q <= valid_mem[set_idx];
		end
	end

	// compare ways, find the lowest free way, draw a random victim
	always_comb begin
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = valid_row_q[w] && (tag_row_q[w] == tag_now);
			if (!valid_row_q[w]) begin
				free_way = WAY_W'(w);
			end
		end
		hit_any    = item_cacheable_q && (|match);
		free_found = ~&valid_row_q;
		lfsr_nxt   = lfsr_step(lfsr_q);
		rnd_ext    = {1'b0, lfsr_nxt[WAY_W-1:0]};
		if (rnd_ext >= (WAY_W + 1)'(WAYS)) begin
			rnd_ext = rnd_ext - (WAY_W + 1)'(WAYS);
		end
		rnd_way = rnd_ext[WAY_W-1:0];
		victim  = free_found ? free_way : rnd_way;
		for (int w = 0; w < WAYS; w++) begin
			tag_row_new[w]   = (WAY_W'(w) == victim) ? tag_now : tag_row_q[w];
			valid_row_new[w] = valid_row_q[w] || (WAY_W'(w) == victim);
		end
	end

	assign wr_en    = cmd.finish && item_cacheable_q && !hit_any;
	assign lfsr_adv = wr_en && !free_found && (WAYS > 1);

	// fill the victim way
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[set_idx] <= tag_row_new;
		end
	end

	// clear or update valid rows
	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			valid_mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			valid_mem[set_idx] <= valid_row_new;
		end
	end

	// advance the LFSR only when it picks a victim
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= '0;
		end else if (lfsr_adv) begin
			lfsr_q <= lfsr_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			delay_q <= hit_any ? hit_delay : miss_delay;
			hit_q   <= hit_any;
			cach_q  <= item_cacheable_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign delay     = delay_q;
	assign hit       = hit_q;
	assign cacheable = cach_q;

	// status back to the controller
	always_comb begin
		st.clr_last      = (clr_cnt_q == SET_W'(SETS - 1));
		st.req_cacheable = (address >= base) && (address <= limit);
		st.line_done     = line_done;
		st.set_done      = set_done;
		st.out_free      = !out_valid_q || !rsp_stall;
	end

endmodule

@@ rtl/core/set_assoc_cache_lookup_lfsr_replace.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_lfsr_replace - set-associative tag store lookup
// Checks each address against the cacheable range and the ways of its set,
// fills a cacheable miss (lowest free way, else LFSR victim); reports the delay.
//
//   channel | signals                              | beat moves on
//   --------+--------------------------------------+----------------------------
//   req     | req_valid, req_stall, address        | req_valid && !req_stall
//   rsp     | rsp_valid, rsp_stall, delay, hit,    | rsp_valid && !rsp_stall
//           | cacheable                            |
//   apb     | psel, penable, pwrite, paddr, pwdata | psel && penable && pwrite
//
// An uncacheable address goes from accept straight to the result stage; a
// cacheable one passes the two address splits, each a single registered step
// whatever LINE_BYTES and SETS are, then the row read and the result and fill.
// One address is in flight at a time; the next is taken once the result is
// in the output register, which holds it while rsp_stall is high.
// After reset a clearing pass zeroes the valid bits one set row at a time;
// req_stall stays high until it finishes.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_lfsr_replace #(
	parameter int unsigned WAYS       = 4,
	parameter int unsigned SETS       = 64,
	parameter int unsigned LINE_BYTES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sacl_pkg::PADDR_W-1:0]   paddr,
	input  logic [sacl_pkg::PDATA_W-1:0]   pwdata,
	output logic [sacl_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [sacl_pkg::ADDR_W-1:0]    address,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [sacl_pkg::DELAY_W-1:0]   delay,
	output logic                           hit,
	output logic                           cacheable
);

	import sacl_pkg::*;

	localparam longint unsigned ADDR_MAX = 64'hFFFF_FFFF;
	localparam longint unsigned LINE_MAX = ADDR_MAX / LINE_BYTES;
	localparam longint unsigned TAG_MAX  = LINE_MAX / SETS;
	localparam int unsigned LINE_W = $clog2(LINE_MAX + 1);
	localparam int unsigned TAG_W  = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;
	localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  limit_q;
	logic [DELAY_W-1:0] hit_delay_q;
	logic [DELAY_W-1:0] miss_delay_q;
	logic [1:0]         reg_idx;
	logic               reg_wr;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= BASE_RST;
			limit_q      <= LIMIT_RST;
			hit_delay_q  <= HIT_RST;
			miss_delay_q <= MISS_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_BASE:  base_q       <= pwdata;
				REG_LIMIT: limit_q      <= pwdata;
				REG_HIT:   hit_delay_q  <= pwdata[DELAY_W-1:0];
				REG_MISS:  miss_delay_q <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		unique case (reg_idx)
			REG_BASE:  prdata = base_q;
			REG_LIMIT: prdata = limit_q;
			REG_HIT:   prdata = PDATA_W'(hit_delay_q);
			REG_MISS:  prdata = PDATA_W'(miss_delay_q);
			default:   prdata = '0;
		endcase
	end

	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	sacl_dp #(
		.WAYS       (WAYS),
		.SETS       (SETS),
		.LINE_BYTES (LINE_BYTES),
		.LINE_W     (LINE_W),
		.TAG_W      (TAG_W),
		.SET_W      (SET_W),
		.WAY_W      (WAY_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.address    (address),
		.base       (base_q),
		.limit      (limit_q),
		.hit_delay  (hit_delay_q),
		.miss_delay (miss_delay_q),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.delay      (delay),
		.hit        (hit),
		.cacheable  (cacheable)
	);

endmodule

@@ rtl/core/sacl_chk.sv @@
// ----------------------------------------------------------------------------
// sacl_chk - port-level checks for the tag lookup
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module sacl_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [sacl_pkg::DELAY_W-1:0] delay,
	input logic                         hit,
	input logic                         cacheable
);

	import sacl_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(delay) && $stable(hit)
			&& $stable(cacheable))
		else $error("response beat changed while stalled");

	// a hit is only possible inside the cacheable range
	a_hit_cacheable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> cacheable)
		else $error("hit reported for an uncacheable address");

	// one address at a time: busy right after an accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a lookup is in flight");

	// a new result only comes out of a lookup in flight
	a_rsp_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared with no lookup in flight");

endmodule

bind set_assoc_cache_lookup_lfsr_replace sacl_chk u_chk (.*);
